// ===== rtl/hfws_pkg.sv =====
// Shared types, constants and fixed-point helpers for the water grid block.
package hfws_pkg;

  localparam int GridW = 256;
  localparam int GridH = 256;
  localparam int FracBits = 16;
  localparam int XW = $clog2(GridW);
  localparam int YW = $clog2(GridH);
  localparam int AW = XW + YW;
  localparam int Cells = GridW * GridH;

  localparam logic [31:0] OneFx = 32'(1) << FracBits;
  localparam logic [31:0] RestFx = 32'(100) << FracBits;

  typedef enum logic [1:0] {
    KIND_SPLASH = 2'd0,
    KIND_TICK = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_TENSION = 2'd0,
    REG_DAMPING = 2'd1,
    REG_SPREAD = 2'd2,
    REG_PASSES = 2'd3
  } reg_idx_t;

  // Datapath operation codes issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE = 4'd0,
    OP_CLEAR = 4'd1,
    OP_SPLASH = 4'd2,
    OP_SPRING = 4'd3,
    OP_COPY = 4'd4,
    OP_COUPLE = 4'd5,
    OP_SAMPLE = 4'd6
  } op_t;

  typedef struct packed {
    op_t op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

  // Truncating fixed-point product of two 32-bit words
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    return p[FracBits +: 32];
  endfunction

endpackage

// ===== rtl/hfws_ctrl.sv =====
// Controller: sequences item handling and hands commands to the datapath.
module hfws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [1:0]        in_kind,
  input  logic [4:0]        pass_count,
  input  logic              out_busy,
  input  hfws_pkg::sts_t    sts,
  output hfws_pkg::cmd_t    cmd,
  output logic              idle,
  output logic              finish
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE = 6'b000010,
    S_RUN = 6'b000100,
    S_COPY = 6'b001000,
    S_COUPLE = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [4:0] passes, passes_next;
  hfws_pkg::op_t op, op_next;
  logic start_next, start;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      passes <= '0;
      op <= hfws_pkg::OP_CLEAR;
      start <= 1'b1;
    end else begin
      state <= state_next;
      passes <= passes_next;
      op <= op_next;
      start <= start_next;
    end
  end

  always_comb begin
    state_next = state;
    passes_next = passes;
    op_next = op;
    start_next = 1'b0;
    case (state)
      S_CLEAR: begin
        if (sts.done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_RUN;
          start_next = 1'b1;
          passes_next = pass_count;
          case (in_kind)
            hfws_pkg::KIND_SPLASH: op_next = hfws_pkg::OP_SPLASH;
            hfws_pkg::KIND_TICK: op_next = hfws_pkg::OP_SPRING;
            hfws_pkg::KIND_SAMPLE: op_next = hfws_pkg::OP_SAMPLE;
            default: op_next = hfws_pkg::OP_IDLE;
          endcase
        end
      end
      S_RUN: begin
        if (sts.done) begin
          if (op == hfws_pkg::OP_SPRING && passes != '0) begin
            state_next = S_COPY;
            op_next = hfws_pkg::OP_COPY;
            start_next = 1'b1;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_COPY: begin
        if (sts.done) begin
          state_next = S_COUPLE;
          op_next = hfws_pkg::OP_COUPLE;
          start_next = 1'b1;
        end
      end
      S_COUPLE: begin
        if (sts.done) begin
          passes_next = passes - 5'd1;
          if (passes == 5'd1) begin
            state_next = S_DONE;
          end else begin
            state_next = S_COPY;
            op_next = hfws_pkg::OP_COPY;
            start_next = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cmd.op = op;
  assign cmd.start = start;
  assign idle = (state == S_IDLE);
  assign finish = (state == S_DONE) && !out_busy;

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_fire_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == S_IDLE) else $error("accept while busy");
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> start) else $error("no start after accept");

endmodule

// ===== rtl/hfws_dp.sv =====
// Datapath: grid memories, spring/coupling/sample arithmetic and sweep counters.
module hfws_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  hfws_pkg::cmd_t       cmd,
  input  logic [7:0]           cell_x,
  input  logic [7:0]           cell_y,
  input  logic [31:0]          amount,
  input  logic [23:0]          sample_x,
  input  logic [23:0]          sample_y,
  input  logic                 in_fire,
  input  logic [30:0]          tension,
  input  logic [30:0]          damping,
  input  logic [30:0]          spread,
  output hfws_pkg::sts_t       sts,
  output logic [31:0]          res_h,
  output logic [31:0]          res_v,
  output logic [31:0]          res_a
);

  localparam int AW = hfws_pkg::AW;
  localparam int XW = hfws_pkg::XW;
  localparam int YW = hfws_pkg::YW;

  // Two buffers per quantity, addressed {buffer, cell}
  logic [31:0] hmem [2*hfws_pkg::Cells];
  logic [31:0] vmem [2*hfws_pkg::Cells];
  logic [31:0] amem [2*hfws_pkg::Cells];

  // Latched item payload
  logic [31:0] dt;
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic [31:0] ps, pt;
  logic [XW-1:0] sx1, sx2;
  logic [YW-1:0] sy1, sy2;
  logic cur, cur_next;

  // Sweep state
  logic active, active_next;
  logic done_next;
  hfws_pkg::op_t op, op_next;
  logic [AW:0] idx, idx_next;
  logic [3:0] ph, ph_next;
  logic [1:0] nslot, nslot_next;
  logic own_q, own_next;
  logic [31:0] rh, rv, ra, h0, v0, t0, t1, acc, own_h;
  logic [31:0] hh [4];
  logic [31:0] vv [4];
  logic [31:0] aa [4];

  logic [AW-1:0] cidx;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  assign cidx = idx[AW-1:0];
  assign cx = cidx[XW-1:0];
  assign cy = cidx[AW-1:XW];

  // Read address and write control
  logic [AW:0] raddr;
  logic we;
  logic [AW:0] waddr;
  logic [31:0] wh, wv, wa;
  logic [31:0] qh, qv, qa;

  always_ff @(posedge clk) begin
    if (we) begin
      hmem[waddr] <= wh;
      vmem[waddr] <= wv;
      amem[waddr] <= wa;
    end
    qh <= hmem[raddr];
    qv <= vmem[raddr];
    qa <= amem[raddr];
  end

  // Neighbor helper for coupling: slot 0..3 = left,right,up,down
  logic nb_ok;
  logic [AW-1:0] nb;
  always_comb begin
    nb_ok = 1'b0;
    nb = cidx;
    case (nslot)
      2'd0: begin nb_ok = cx != '0; nb = {cy, cx - XW'(1)}; end
      2'd1: begin nb_ok = cx != XW'(hfws_pkg::GridW - 1); nb = {cy, cx + XW'(1)}; end
      2'd2: begin nb_ok = cy != '0; nb = {cy - YW'(1), cx}; end
      default: begin nb_ok = cy != YW'(hfws_pkg::GridH - 1); nb = {cy + YW'(1), cx}; end
    endcase
  end

  logic [AW-1:0] samp_a;
  always_comb begin
    case (ph[1:0])
      2'd0: samp_a = {sy1, sx1};
      2'd1: samp_a = {sy1, sx2};
      2'd2: samp_a = {sy2, sx1};
      default: samp_a = {sy2, sx2};
    endcase
  end

  // Memory access per op; sweeps other than clear take phases, one multiply at most
  always_comb begin
    raddr = {cur, cidx};
    we = 1'b0;
    waddr = {cur, cidx};
    wh = h0;
    wv = v0;
    wa = acc;
    case (op)
      hfws_pkg::OP_CLEAR: begin
        we = active;
        waddr = idx;
        wh = '0; wv = '0; wa = '0;
      end
      hfws_pkg::OP_SPLASH: begin
        raddr = {cur, {py, px}};
        waddr = {cur, {py, px}};
        we = active && ph == 4'd2;
        wh = qh; wv = qv + dt; wa = qa;
      end
      hfws_pkg::OP_SPRING: begin
        we = active && ph == 4'd7;
        wh = h0 + t0; wv = v0 + t1; wa = acc;
      end
      hfws_pkg::OP_COPY: begin
        raddr = {cur, cidx};
        waddr = {!cur, cidx};
        we = active && ph == 4'd2;
        wh = qh; wv = qv; wa = qa;
      end
      hfws_pkg::OP_COUPLE: begin
        // Heights in the copy equal the live buffer, so every read comes from the copy
        raddr = own_q ? {!cur, nb} : {!cur, cidx};
        waddr = {!cur, nb};
        we = active && own_q && ph == 4'd4 && nb_ok;
        wh = qh; wv = qv + t1; wa = qa + t1;
      end
      hfws_pkg::OP_SAMPLE: raddr = {cur, samp_a};
      default: ;
    endcase
  end

  // Phase and index advance
  logic cell_last;
  assign cell_last = cidx == AW'(hfws_pkg::Cells - 1);

  always_comb begin
    active_next = active;
    done_next = 1'b0;
    op_next = op;
    idx_next = idx;
    ph_next = ph;
    nslot_next = nslot;
    own_next = own_q;
    cur_next = cur;
    if (cmd.start) begin
      active_next = (cmd.op != hfws_pkg::OP_IDLE);
      done_next = (cmd.op == hfws_pkg::OP_IDLE);
      op_next = cmd.op;
      idx_next = '0;
      ph_next = '0;
      nslot_next = '0;
      own_next = 1'b0;
    end else if (active) begin
      case (op)
        hfws_pkg::OP_CLEAR: begin
          idx_next = idx + (AW+1)'(1);
          if (idx == (AW+1)'(2*hfws_pkg::Cells - 1)) begin
            active_next = 1'b0; done_next = 1'b1;
          end
        end
        hfws_pkg::OP_SPLASH: begin
          ph_next = ph + 4'd1;
          if (ph == 4'd2) begin active_next = 1'b0; done_next = 1'b1; end
        end
        hfws_pkg::OP_SPRING, hfws_pkg::OP_COPY: begin
          if (ph == ((op == hfws_pkg::OP_SPRING) ? 4'd7 : 4'd2)) begin
            ph_next = '0;
            idx_next = idx + (AW+1)'(1);
            if (cell_last) begin active_next = 1'b0; done_next = 1'b1; end
          end else begin
            ph_next = ph + 4'd1;
          end
        end
        hfws_pkg::OP_COUPLE: begin
          // own height: 0 issue, 1 capture; per neighbor: 0 issue, 2 d, 3 k, 4 write
          if (!own_q) begin
            if (ph == 4'd1) begin
              own_next = 1'b1;
              ph_next = '0;
            end else begin
              ph_next = ph + 4'd1;
            end
          end else if (ph == 4'd4 || !nb_ok) begin
            // Move to the next neighbor slot; a missing neighbor is skipped from phase 0
            ph_next = '0;
            nslot_next = nslot + 2'd1;
            if (nslot == 2'd3) begin
              own_next = 1'b0;
              idx_next = idx + (AW+1)'(1);
              if (cell_last) begin
                active_next = 1'b0; done_next = 1'b1; cur_next = !cur;
              end
            end
          end else begin
            ph_next = ph + 4'd1;
          end
        end
        hfws_pkg::OP_SAMPLE: begin
          ph_next = ph + 4'd1;
          if (ph == 4'd12) begin active_next = 1'b0; done_next = 1'b1; end
        end
        default: active_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cur <= 1'b1;
      sts.done <= 1'b0;
      op <= hfws_pkg::OP_IDLE;
      idx <= '0;
      ph <= '0;
      nslot <= '0;
      own_q <= 1'b0;
    end else begin
      active <= active_next;
      cur <= cur_next;
      sts.done <= done_next;
      op <= op_next;
      idx <= idx_next;
      ph <= ph_next;
      nslot <= nslot_next;
      own_q <= own_next;
    end
  end

  // Datapath arithmetic registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dt <= amount;
      px <= cell_x[XW-1:0];
      py <= cell_y[YW-1:0];
      ps <= {16'b0, sample_x[15:0]};
      pt <= {16'b0, sample_y[15:0]};
      sx1 <= (sample_x[23:16] > 8'(hfws_pkg::GridW - 1)) ? XW'(hfws_pkg::GridW - 1)
             : sample_x[16 +: XW];
      sy1 <= (sample_y[23:16] > 8'(hfws_pkg::GridH - 1)) ? YW'(hfws_pkg::GridH - 1)
             : sample_y[16 +: YW];
    end
    sx2 <= (sx1 == XW'(hfws_pkg::GridW - 1)) ? sx1 : sx1 + XW'(1);
    sy2 <= (sy1 == YW'(hfws_pkg::GridH - 1)) ? sy1 : sy1 + YW'(1);
    case (op)
      hfws_pkg::OP_SPRING: begin
        case (ph)
          4'd2: begin h0 <= qh; v0 <= qv; end
          4'd3: t0 <= hfws_pkg::fmul(32'(0) - {1'b0, tension}, h0 - hfws_pkg::RestFx);
          4'd4: t1 <= hfws_pkg::fmul({1'b0, damping}, v0);
          4'd5: begin acc <= t0 - t1; t0 <= hfws_pkg::fmul(v0, dt); end
          4'd6: t1 <= hfws_pkg::fmul(acc, dt);
          default: ;
        endcase
      end
      hfws_pkg::OP_COUPLE: begin
        if (!own_q) begin
          if (ph == 4'd1) own_h <= qh;
        end else begin
          case (ph)
            4'd2: t0 <= hfws_pkg::fmul({1'b0, spread}, own_h - qh);
            4'd3: t1 <= hfws_pkg::fmul(t0, dt);
            default: ;
          endcase
        end
      end
      hfws_pkg::OP_SAMPLE: begin
        // Corner data arrives in the cycle after its address: P11, P21, P12, P22
        if (ph inside {[4'd1:4'd4]}) begin
          hh[ph[1:0] - 2'd1] <= qh;
          vv[ph[1:0] - 2'd1] <= qv;
          aa[ph[1:0] - 2'd1] <= qa;
        end
      end
      default: ;
    endcase
  end

  // Sample interpolation, one multiply per quantity per phase
  logic upper;
  logic [31:0] fs, ft;
  logic [1:0] base, ea, eb;
  assign upper = (ps + pt) > hfws_pkg::OneFx;
  assign fs = upper ? hfws_pkg::OneFx - ps : ps;
  assign ft = upper ? hfws_pkg::OneFx - pt : pt;
  assign base = upper ? 2'd3 : 2'd0;
  assign ea = upper ? 2'd2 : 2'd1;
  assign eb = upper ? 2'd1 : 2'd2;

  always_ff @(posedge clk) begin
    if (op == hfws_pkg::OP_SAMPLE) begin
      case (ph)
        4'd8: begin
          rh <= hh[base] + hfws_pkg::fmul(fs, hh[ea] - hh[base]);
          rv <= vv[base] + hfws_pkg::fmul(fs, vv[ea] - vv[base]);
          ra <= aa[base] + hfws_pkg::fmul(fs, aa[ea] - aa[base]);
        end
        4'd9: begin
          rh <= rh + hfws_pkg::fmul(ft, hh[eb] - hh[base]);
          rv <= rv + hfws_pkg::fmul(ft, vv[eb] - vv[base]);
          ra <= ra + hfws_pkg::fmul(ft, aa[eb] - aa[base]);
        end
        default: ;
      endcase
    end
  end

  assign res_h = rh;
  assign res_v = rv;
  assign res_a = ra;

endmodule

// ===== rtl/height_field_water_step_top.sv =====
// Top level of the height-field water grid block.
// Usage:
//  Input channel (valid/ready) carries one item: kind, cell_x, cell_y, amount,
//  sample_x, sample_y. Kind 0 splashes one cell, kind 1 advances the grid by
//  amount seconds, kind 2 samples an interpolated point, kind 3 does nothing.
//  Output channel (valid/ready) returns one beat per item with answered_kind
//  and the sampled height, velocity and acceleration (zero unless sample).
//  Configuration is a plain write port (cfg_we, cfg_index, cfg_data) for
//  tension, damping, spread and pass_count; write only while idle.
//  A splash, a sample or a kind 3 item runs a single datapath operation. A tick
//  runs the spring sweep over every point, then per pass a buffer copy and a
//  coupling sweep that visits each in-bound neighbor of a point and skips a
//  missing one. One item is in flight at a time; the next can be taken once
//  the result is loaded into the output register.
//  After reset a clearing pass writes zero to all 131072 addresses of both
//  buffers, during which no item is accepted.
//  When the receiver stalls, the result is held; a new item can still be
//  taken, but its result waits until the held one is accepted.
module height_field_water_step_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  cell_x,
  input  logic [7:0]  cell_y,
  input  logic signed [31:0] amount,
  input  logic [23:0] sample_x,
  input  logic [23:0] sample_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  answered_kind,
  output logic signed [31:0] height_out,
  output logic signed [31:0] velocity_out,
  output logic signed [31:0] accel_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  logic [30:0] tension, damping, spread;
  logic [4:0] pass_count;
  logic [1:0] kind_q;
  hfws_pkg::cmd_t cmd;
  hfws_pkg::sts_t sts;
  logic idle, finish, in_fire;
  logic [31:0] rh, rv, ra;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= 31'd6553;
      damping <= 31'd1638;
      spread <= 31'd49152;
      pass_count <= 5'd8;
    end else if (cfg_we) begin
      case (hfws_pkg::reg_idx_t'(cfg_index))
        hfws_pkg::REG_TENSION: tension <= cfg_data;
        hfws_pkg::REG_DAMPING: damping <= cfg_data;
        hfws_pkg::REG_SPREAD: spread <= cfg_data;
        default: pass_count <= cfg_data[4:0];
      endcase
    end
  end

  assign in_ready = idle;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q <= kind;
    end
  end

  hfws_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_kind(kind),
    .pass_count(pass_count), .out_busy(out_valid && !out_ready), .sts(sts),
    .cmd(cmd), .idle(idle), .finish(finish)
  );

  hfws_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cell_x(cell_x), .cell_y(cell_y),
    .amount(amount), .sample_x(sample_x), .sample_y(sample_y), .in_fire(in_fire),
    .tension(tension), .damping(damping), .spread(spread), .sts(sts),
    .res_h(rh), .res_v(rv), .res_a(ra)
  );

  // Output register: load result beat, drop on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      answered_kind <= kind_q;
      height_out <= (kind_q == hfws_pkg::KIND_SAMPLE) ? rh : '0;
      velocity_out <= (kind_q == hfws_pkg::KIND_SAMPLE) ? rv : '0;
      accel_out <= (kind_q == hfws_pkg::KIND_SAMPLE) ? ra : '0;
    end
  end

endmodule
